// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the random walk step block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define DFRW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DFRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dfrw_pkg.sv
// Package for the delayed feedback random walk step block.
// Widths, reset values, register indexes, types and the scaled tanh table.
// No dependencies.
`timescale 1ns / 1ps

package dfrw_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 64;
   localparam int HALF_RANGE            = 50;
   localparam int TANH_ENTRIES          = 16;
   localparam int TANH_KNOWN            = 12;
   localparam int TANH_LIMIT = (TANH_ENTRIES < TANH_KNOWN) ? TANH_ENTRIES : TANH_KNOWN;
   localparam int TANH_IDX_W = $clog2(TANH_KNOWN);

   localparam int RND_W    = 32;
   localparam int WALK_W   = 7;
   localparam int OFFSET_W = 7;
   localparam int LAG_W    = 6;
   localparam int ARG_W    = 9;
   localparam int Q30_W    = 31;
   localparam int SCALED_W = 38;
   localparam int THR_W    = 39;
   localparam int MARGIN_W = 41;

   localparam int PROB_NUM   = 99;
   localparam int ROUND_BIAS = 50;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_D = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_A  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_B  = 2'd2;

   localparam int OFFSET_D_RESET = 20;
   localparam int DELAY_A_RESET  = 50;
   localparam int DELAY_B_RESET  = 0;
   localparam int PRESENT_RESET  = 1;

   typedef logic signed [WALK_W-1:0]   walk_type;
   typedef logic signed [ARG_W-1:0]    arg_type;
   typedef logic signed [SCALED_W-1:0] scaled_type;
   typedef logic signed [THR_W-1:0]    thr_type;

   localparam walk_type WALK_MAX = WALK_W'(HALF_RANGE);
   localparam walk_type WALK_MIN = WALK_W'(-HALF_RANGE);

   // tanh(k) in Q1.30 for k = 0 .. TANH_KNOWN-1
   localparam logic [Q30_W-1:0] TANH_ONE = 31'd1073741824;
   localparam logic [Q30_W-1:0] TANH_Q30 [TANH_KNOWN] = '{
      31'd0,          31'd817755498,  31'd1035116732, 31'd1068431906,
      31'd1073021665, 31'd1073644333, 31'd1073728629, 31'd1073740038,
      31'd1073741582, 31'd1073741791, 31'd1073741820, 31'd1073741823
   };

   typedef struct packed {
      logic fwd;
      logic written;
   } tap_sel_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_d;
      logic                zero_a;
      logic                zero_b;
   } step_cfg_type;

   // 99 * tanh(k) in Q.30, saturated outside the table
   function automatic scaled_type tanh_scaled(input arg_type k);
      logic [ARG_W-1:0]    mag;
      logic [SCALED_W-1:0] unit;
      mag = k[ARG_W-1] ? ARG_W'(-k) : ARG_W'(k);
      if (mag >= ARG_W'(TANH_LIMIT)) begin
         unit = SCALED_W'(TANH_ONE) * SCALED_W'(PROB_NUM);
      end else begin
         unit = SCALED_W'(TANH_Q30[mag[TANH_IDX_W-1:0]]) * SCALED_W'(PROB_NUM);
      end
      return k[ARG_W-1] ? -scaled_type'(unit) : scaled_type'(unit);
   endfunction

endpackage

// File: rtl/core/dfrw_if.sv
// Channel interfaces of the random walk step block: input, result, register write.
// Depends on dfrw_pkg.
`timescale 1ns / 1ps

interface dfrw_req_if import dfrw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RND_W-1:0] random_fraction;
   modport source (output valid, output random_fraction, input ready);
   modport sink (input valid, input random_fraction, output ready);
endinterface

interface dfrw_rsp_if import dfrw_pkg::*; ();
   logic     valid;
   logic     ready;
   walk_type walk_value;
   logic     stepped_up;
   modport source (output valid, output walk_value, output stepped_up, input ready);
   modport sink (input valid, input walk_value, input stepped_up, output ready);
endinterface

interface dfrw_csr_if import dfrw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/dfrw_ring.sv
// History ring memory: one write port, two read ports, registered read data.
// Depends on dfrw_pkg.
`timescale 1ns / 1ps

module dfrw_ring import dfrw_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT,
   localparam int IdxW = $clog2(HISTORY_DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IdxW-1:0] wr_addr,
   input  walk_type        wr_data,
   input  logic            rd_en,
   input  logic [IdxW-1:0] rd_addr_a,
   input  logic [IdxW-1:0] rd_addr_b,
   output walk_type        rd_data_a,
   output walk_type        rd_data_b
);

   walk_type mem_ff [HISTORY_DEPTH];
   walk_type q_a_ff;
   walk_type q_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_a_ff <= mem_ff[rd_addr_a];
         q_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = q_a_ff;
   assign rd_data_b = q_b_ff;

endmodule

// File: rtl/core/dfrw_hist.sv
// History tap unit: ring pointer, fill count, lag address generation and
// write-to-read forwarding around the ring memory. Depends on dfrw_pkg, dfrw_ring.
`timescale 1ns / 1ps

module dfrw_hist import dfrw_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT,
   localparam int IdxW = $clog2(HISTORY_DEPTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  walk_type        push_value,
   input  logic            look,
   input  logic [IdxW-1:0] back_a,
   input  logic [IdxW-1:0] back_b,
   output walk_type        hist_a,
   output walk_type        hist_b
);

   localparam int CntW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [IdxW:0]   Depth    = (IdxW + 1)'(HISTORY_DEPTH);
   localparam logic [IdxW-1:0] LastIdx  = IdxW'(HISTORY_DEPTH - 1);
   localparam logic [CntW-1:0] FillFull = CntW'(HISTORY_DEPTH);

   logic [IdxW-1:0] newest_ff, newest_in;
   logic [CntW-1:0] fill_ff, fill_in;
   tap_sel_type     sel_a_ff, sel_a_in;
   tap_sel_type     sel_b_ff, sel_b_in;
   walk_type        fwd_value_ff, fwd_value_in;

   logic [IdxW-1:0] wr_addr;
   logic [IdxW-1:0] rd_addr_a;
   logic [IdxW-1:0] rd_addr_b;
   walk_type        q_a;
   walk_type        q_b;

   function automatic logic [IdxW-1:0] tap_addr(input logic [IdxW-1:0] base,
                                                input logic [IdxW-1:0] back);
      logic [IdxW:0] wide;
      if ({1'b0, base} >= {1'b0, back}) begin
         wide = {1'b0, base} - {1'b0, back};
      end else begin
         wide = {1'b0, base} + Depth - {1'b0, back};
      end
      return wide[IdxW-1:0];
   endfunction

   function automatic tap_sel_type tap_sel(input logic            fwd_en,
                                           input logic [IdxW-1:0] addr,
                                           input logic [IdxW-1:0] waddr,
                                           input logic [CntW-1:0] fill);
      tap_sel_type sel;
      sel.fwd     = fwd_en && (addr == waddr);
      sel.written = (addr == '0) ? (fill == FillFull) : (fill >= CntW'(addr));
      return sel;
   endfunction

   always_comb begin
      wr_addr   = (newest_ff == LastIdx) ? '0 : newest_ff + 1'b1;
      newest_in = push ? wr_addr : newest_ff;
      fill_in   = (push && (fill_ff != FillFull)) ? fill_ff + 1'b1 : fill_ff;
      // addresses seen after the push that completes at this edge
      rd_addr_a = tap_addr(newest_in, back_a);
      rd_addr_b = tap_addr(newest_in, back_b);
      sel_a_in     = look ? tap_sel(push, rd_addr_a, wr_addr, fill_in) : sel_a_ff;
      sel_b_in     = look ? tap_sel(push, rd_addr_b, wr_addr, fill_in) : sel_b_ff;
      fwd_value_in = look ? push_value : fwd_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
         fill_ff   <= '0;
      end else begin
         newest_ff <= newest_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_a_ff     <= sel_a_in;
      sel_b_ff     <= sel_b_in;
      fwd_value_ff <= fwd_value_in;
   end

   dfrw_ring #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (push),
      .wr_addr   (wr_addr),
      .wr_data   (push_value),
      .rd_en     (look),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (q_a),
      .rd_data_b (q_b)
   );

   assign hist_a = sel_a_ff.fwd ? fwd_value_ff : (sel_a_ff.written ? q_a : '0);
   assign hist_b = sel_b_ff.fwd ? fwd_value_ff : (sel_b_ff.written ? q_b : '0);

endmodule

// File: rtl/core/dfrw_step.sv
// Walk step logic: feedback tanh terms, probability compare and saturating step.
// Depends on dfrw_pkg.
`timescale 1ns / 1ps

module dfrw_step import dfrw_pkg::*; (
   input  step_cfg_type cfg,
   input  walk_type     present,
   input  walk_type     hist_a,
   input  walk_type     hist_b,
   input  thr_type      thresh,
   output logic         step_up,
   output walk_type     next_value
);

   walk_type                    xa;
   walk_type                    xb;
   arg_type                     d_arg;
   arg_type                     ka;
   arg_type                     kb;
   scaled_type                  ta;
   scaled_type                  tb;
   logic signed [MARGIN_W-1:0]  margin;

   always_comb begin
      xa     = cfg.zero_a ? present : hist_a;
      xb     = cfg.zero_b ? present : hist_b;
      d_arg  = ARG_W'($signed({1'b0, cfg.offset_d}));
      ka     = d_arg - ARG_W'(xa);
      kb     = ARG_W'(xb) + d_arg;
      ta     = tanh_scaled(ka);
      tb     = tanh_scaled(kb);
      // 99*(tA - tB) against the pre-scaled random threshold
      margin = MARGIN_W'(ta) - MARGIN_W'(tb) - MARGIN_W'(thresh);
      step_up = !margin[MARGIN_W-1] && (margin != '0);
      if (step_up) begin
         next_value = (present == WALK_MAX) ? present : present + WALK_W'(1);
      end else begin
         next_value = (present == WALK_MIN) ? present : present - WALK_W'(1);
      end
   end

endmodule

// File: rtl/core/delayed_feedback_random_walk_step.sv
// Top level of the delayed feedback random walk step block.
// Depends on dfrw_pkg, dfrw_if, dfrw_hist, dfrw_step, assert_macros.svh.
//
//   channel  | role   | handshake     | payload
//   req_ch   | sink   | valid / ready | random_fraction [31:0]
//   rsp_ch   | source | valid / ready | walk_value [6:0] signed, stepped_up
//   csr_ch   | sink   | valid / ready | index [1:0], wdata [6:0]
//
// One item per cycle sustained while the output is taken; a result passes the step stage,
// then the output register. The step stage closes the present-value loop combinationally:
// lag select, tanh table, threshold compare and saturating update. Ring reads issue at transfer.
// Synchronous reset; the ring reads as zero until written (fill count, no clear pass).
// The step stage stalls only while the output register is full and not taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module delayed_feedback_random_walk_step import dfrw_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   dfrw_req_if.sink    req_ch,
   dfrw_rsp_if.source  rsp_ch,
   dfrw_csr_if.sink    csr_ch
);

   localparam int IdxW = $clog2(HISTORY_DEPTH);
   localparam logic [IdxW-1:0] BackAReset =
      IdxW'((DELAY_A_RESET + HISTORY_DEPTH - 1) % HISTORY_DEPTH);
   localparam logic [IdxW-1:0] BackBReset =
      IdxW'((DELAY_B_RESET + HISTORY_DEPTH - 1) % HISTORY_DEPTH);

   logic                s1_valid_ff, s1_valid_in;
   thr_type             thr_ff, thr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   walk_type            walk_ff, walk_in;
   logic                up_ff, up_in;
   walk_type            present_ff, present_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                zero_a_ff, zero_a_in;
   logic                zero_b_ff, zero_b_in;
   logic [IdxW-1:0]     back_a_ff, back_a_in;
   logic [IdxW-1:0]     back_b_ff, back_b_in;

   logic                accept;
   logic                s1_go;
   logic                csr_write;
   logic [LAG_W-1:0]    lag_w;
   logic [IdxW-1:0]     back_w;
   logic signed [RND_W-1:0] centred;
   thr_type             cx;
   thr_type             thr_w;
   walk_type            hist_a;
   walk_type            hist_b;
   step_cfg_type        step_cfg;
   logic                step_up;
   walk_type            next_value;

   assign s1_go        = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // (lag - 1) mod depth
   assign lag_w = csr_ch.wdata[LAG_W-1:0];
   always_comb begin
      back_w = '0;
      for (int i = 0; i < 2 ** LAG_W; i++) begin
         if (lag_w == LAG_W'(i)) begin
            back_w = IdxW'((i + HISTORY_DEPTH - 1) % HISTORY_DEPTH);
         end
      end
   end

   always_comb begin
      offset_in = offset_ff;
      zero_a_in = zero_a_ff;
      back_a_in = back_a_ff;
      zero_b_in = zero_b_ff;
      back_b_in = back_b_ff;
      if (csr_write) begin
         case (csr_ch.index)
            CSR_OFFSET_D: begin
               offset_in = csr_ch.wdata[OFFSET_W-1:0];
            end
            CSR_DELAY_A: begin
               zero_a_in = (lag_w == '0);
               back_a_in = back_w;
            end
            CSR_DELAY_B: begin
               zero_b_in = (lag_w == '0);
               back_b_in = back_w;
            end
            default: begin
            end
         endcase
      end
   end

   // threshold 100*(rnd - 2^31) + 50, less one when non-negative
   always_comb begin
      centred = $signed({~req_ch.random_fraction[RND_W-1],
                         req_ch.random_fraction[RND_W-2:0]});
      cx      = THR_W'(centred);
      thr_w   = (cx <<< 6) + (cx <<< 5) + (cx <<< 2) + THR_W'(ROUND_BIAS)
                - THR_W'(!centred[RND_W-1]);
   end

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      thr_in       = accept ? thr_w : thr_ff;
      present_in   = s1_go ? next_value : present_ff;
      walk_in      = s1_go ? next_value : walk_ff;
      up_in        = s1_go ? step_up : up_ff;
      rsp_valid_in = s1_go ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         present_ff   <= WALK_W'(PRESENT_RESET);
         offset_ff    <= OFFSET_W'(OFFSET_D_RESET);
         zero_a_ff    <= (DELAY_A_RESET == 0);
         back_a_ff    <= BackAReset;
         zero_b_ff    <= (DELAY_B_RESET == 0);
         back_b_ff    <= BackBReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         offset_ff    <= offset_in;
         zero_a_ff    <= zero_a_in;
         back_a_ff    <= back_a_in;
         zero_b_ff    <= zero_b_in;
         back_b_ff    <= back_b_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_ff  <= thr_in;
      walk_ff <= walk_in;
      up_ff   <= up_in;
   end

   dfrw_hist #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_go),
      .push_value (present_ff),
      .look       (accept),
      .back_a     (back_a_ff),
      .back_b     (back_b_ff),
      .hist_a     (hist_a),
      .hist_b     (hist_b)
   );

   assign step_cfg.offset_d = offset_ff;
   assign step_cfg.zero_a   = zero_a_ff;
   assign step_cfg.zero_b   = zero_b_ff;

   dfrw_step u_step (
      .cfg        (step_cfg),
      .present    (present_ff),
      .hist_a     (hist_a),
      .hist_b     (hist_b),
      .thresh     (thr_ff),
      .step_up    (step_up),
      .next_value (next_value)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.walk_value = walk_ff;
   assign rsp_ch.stepped_up = up_ff;

   `DFRW_ASSERT(a_present_range, clock, reset, (present_ff <= WALK_MAX) && (present_ff >= WALK_MIN), "walk value out of range")
   `DFRW_ASSERT_NEXT(a_rsp_load, clock, reset, s1_go, rsp_valid_ff && (walk_ff == present_ff), "result differs from present value")
   `DFRW_ASSERT_NEXT(a_step_up_dir, clock, reset, s1_go && step_up, present_ff >= $past(present_ff), "up step lowered the walk")
   `DFRW_ASSERT_NEXT(a_step_dn_dir, clock, reset, s1_go && !step_up, present_ff <= $past(present_ff), "down step raised the walk")

endmodule

// File: verif/tb_delayed_feedback_random_walk_step.sv
// Testbench for delayed_feedback_random_walk_step: drives random fractions through the
// request channel, predicts each walk step in a local model and checks every response.
// Depends on dfrw_pkg, the dfrw channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_delayed_feedback_random_walk_step;
   import dfrw_pkg::*;

   typedef enum int {PHASE_PLAIN, PHASE_PAUSE, PHASE_HOLD} phase_kind_type;

   typedef struct packed {
      walk_type walk_value;
      logic     stepped_up;
   } walk_result_type;

   localparam int                   DEPTH         = HISTORY_DEPTH_DEFAULT;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;
   localparam int                   PROB_DEN      = 100;
   localparam longint               PROB_HALF     = 64'sd2147483648;
   localparam int                   PHASE_ITEMS   = 230;
   localparam int                   LONG_HOLD     = 400;
   localparam int                   SETTLE_CYCLES = 4;
   localparam int                   IDLE_LIMIT    = 2000;

   logic clock;
   logic reset;

   dfrw_req_if req_ch ();
   dfrw_rsp_if rsp_ch ();
   dfrw_csr_if csr_ch ();

   delayed_feedback_random_walk_step DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // local copy of the walk state and settings
   int                  ring_vals [DEPTH];
   int                  newest_slot;
   int                  walk_now;
   logic [OFFSET_W-1:0] cfg_offset;
   logic [LAG_W-1:0]    cfg_lag_a;
   logic [LAG_W-1:0]    cfg_lag_b;

   logic [RND_W-1:0] fraction_queue [$];
   walk_result_type  walk_expected [$];
   int               mismatch_count;
   int               gap_left;
   int               burst_left;
   int               hold_left;
   int               mode_left;
   int               stall_mode;
   int               long_stall_req;
   int               long_stall_ack;
   int               idle_cycles;

   logic [RND_W-1:0] corner_fractions [20] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
      32'h7FFF_FFFE, 32'h0000_0001, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'h4000_0000, 32'hC000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678
   };

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint tanh_q30_at(input int k);
      int     mag;
      longint v;
      mag = (k < 0) ? -k : k;
      if (mag >= TANH_ENTRIES || mag >= TANH_KNOWN) v = longint'(TANH_ONE);
      else v = longint'(TANH_Q30[mag]);
      return (k < 0) ? -v : v;
   endfunction

   function automatic int walk_at_lag(input logic [LAG_W-1:0] lag);
      int back;
      if (lag == '0) return walk_now;
      back = (int'(lag) - 1) % DEPTH;
      return ring_vals[(newest_slot + DEPTH - back) % DEPTH];
   endfunction

   function automatic void advance_walk(input logic [RND_W-1:0] frac);
      int              d;
      longint          diff;
      longint          scaled;
      longint          adj;
      longint          prob;
      longint          frac_l;
      logic            up;
      int              nxt;
      walk_result_type res;
      d      = int'(cfg_offset);
      diff   = tanh_q30_at(d - walk_at_lag(cfg_lag_a)) - tanh_q30_at(walk_at_lag(cfg_lag_b) + d);
      scaled = diff * PROB_NUM;
      adj    = (((scaled < 0) ? -scaled : scaled) + ROUND_BIAS) / PROB_DEN;
      if (scaled < 0) adj = -adj;
      prob   = PROB_HALF + adj;
      frac_l = longint'({32'd0, frac});
      up     = (frac_l < prob);
      nxt    = walk_now + (up ? 1 : -1);
      if (nxt > HALF_RANGE) nxt = HALF_RANGE;
      if (nxt < -HALF_RANGE) nxt = -HALF_RANGE;
      newest_slot = (newest_slot + 1) % DEPTH;
      ring_vals[newest_slot] = walk_now;
      walk_now = nxt;
      res.walk_value = walk_type'(nxt);
      res.stepped_up = up;
      walk_expected.push_back(res);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
         burst_left   <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) advance_walk(req_ch.random_fraction);
         if (req_ch.valid && !req_ch.ready) begin
         end else if (gap_left != 0) begin
            gap_left     <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (fraction_queue.size() != 0) begin
            req_ch.valid           <= 1'b1;
            req_ch.random_fraction <= fraction_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern in windows, plus long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         hold_left      <= 0;
         mode_left      <= 0;
         stall_mode     <= 0;
         long_stall_ack <= 0;
      end else if (long_stall_req != long_stall_ack) begin
         long_stall_ack <= long_stall_req;
         hold_left      <= LONG_HOLD;
         rsp_ch.ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 160);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      walk_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (walk_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer walk_value=%0d stepped_up=%0b",
                                      rsp_ch.walk_value, rsp_ch.stepped_up));
         end else begin
            want = walk_expected.pop_front();
            if (rsp_ch.walk_value !== want.walk_value)
               report_mismatch($sformatf("walk_value got %0d want %0d",
                                         rsp_ch.walk_value, want.walk_value));
            if (rsp_ch.stepped_up !== want.stepped_up)
               report_mismatch($sformatf("stepped_up got %0b want %0b",
                                         rsp_ch.stepped_up, want.stepped_up));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_OFFSET_D: cfg_offset = data[OFFSET_W-1:0];
         CSR_DELAY_A:  cfg_lag_a  = data[LAG_W-1:0];
         CSR_DELAY_B:  cfg_lag_b  = data[LAG_W-1:0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (fraction_queue.size() != 0 || walk_expected.size() != 0 || req_ch.valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] d, input logic [CSR_DATA_W-1:0] a,
                            input logic [CSR_DATA_W-1:0] b, input phase_kind_type kind);
      logic [RND_W-1:0] batch [$];
      logic [RND_W-1:0] val;
      logic [RND_W-1:0] off;
      int               pick;
      int               run_len;
      int               i;
      write_reg(CSR_OFFSET_D, d);
      write_reg(CSR_DELAY_A, a);
      write_reg(CSR_DELAY_B, b);
      while (batch.size() < PHASE_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            // long one-sided runs push the walk into saturation
            run_len = $urandom_range(8, 100);
            val     = (pick == 0) ? '0 : '1;
            while (run_len != 0 && batch.size() < PHASE_ITEMS) begin
               batch.push_back(val);
               run_len--;
            end
         end else if (pick < 5) begin
            off = $urandom_range(0, 32'h0100_0000);
            batch.push_back($urandom_range(0, 1) ? 32'h8000_0000 + off : 32'h8000_0000 - off);
         end else begin
            batch.push_back($urandom);
         end
      end
      @(negedge clock);
      for (i = 0; i < PHASE_ITEMS; i++) begin
         if (kind == PHASE_PAUSE && i == PHASE_ITEMS / 2) begin
            wait_drained();
            @(negedge clock);
         end
         fraction_queue.push_back(batch[i]);
      end
      if (kind == PHASE_HOLD) long_stall_req++;
      wait_drained();
   endtask

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.random_fraction = '0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = '0;
      csr_ch.wdata           = '0;
      mismatch_count         = 0;
      long_stall_req         = 0;
      idle_cycles            = 0;
      foreach (ring_vals[i]) ring_vals[i] = 0;
      newest_slot = 0;
      walk_now    = PRESENT_RESET;
      cfg_offset  = OFFSET_W'(OFFSET_D_RESET);
      cfg_lag_a   = LAG_W'(DELAY_A_RESET);
      cfg_lag_b   = LAG_W'(DELAY_B_RESET);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (corner_fractions[i]) fraction_queue.push_back(corner_fractions[i]);
      wait_drained();

      run_phase(7'd0, 7'd1, 7'd0, PHASE_PLAIN);
      run_phase(7'd127, 7'd63, 7'd63, PHASE_PAUSE);
      write_reg(CSR_UNUSED, 7'($urandom));
      // upper bit set on the lag writes: lag a lands on zero, lag b on 63
      run_phase(7'd3, 7'h40, 7'h7F, PHASE_PLAIN);
      run_phase(7'd10, 7'd2, 7'd1, PHASE_HOLD);
      run_phase(7'($urandom_range(0, 15)), 7'($urandom_range(1, 63)),
                7'($urandom_range(0, 63)), PHASE_PLAIN);
      run_phase(7'($urandom), 7'($urandom), 7'($urandom), PHASE_PLAIN);
      run_phase(7'd20, 7'd50, 7'd0, PHASE_PLAIN);
      run_phase(7'($urandom_range(0, 6)), 7'($urandom_range(0, 63)),
                7'($urandom_range(0, 63)), PHASE_PAUSE);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/dfrw_pkg.sv
rtl/core/dfrw_if.sv
rtl/core/dfrw_ring.sv
rtl/core/dfrw_hist.sv
rtl/core/dfrw_step.sv
rtl/core/delayed_feedback_random_walk_step.sv
verif/tb_delayed_feedback_random_walk_step.sv
